>>> hdl/assert_macros.svh
// Assertion macros shared by the CRT controller modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> hdl/crtc_pkg.sv
// Types and constants shared by the CRT controller register block.
package crtc_pkg;

  localparam int LEN_W   = 21;
  localparam int MUL_A_W = 13;
  localparam int MUL_B_W = 9;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  typedef enum logic [2:0] {
    OP_WRITE_ADDR   = 3'd0,
    OP_WRITE_DATA   = 3'd1,
    OP_READ_STATUS  = 3'd2,
    OP_READ_DATA    = 3'd3,
    OP_TICK         = 3'd4,
    OP_PEN_STROBE   = 3'd5
  } op_t;

  localparam logic [4:0] REG_HTOT          = 5'd0;
  localparam logic [4:0] REG_HDISP         = 5'd1;
  localparam logic [4:0] REG_VTOT          = 5'd4;
  localparam logic [4:0] REG_VADJ          = 5'd5;
  localparam logic [4:0] REG_VDISP         = 5'd6;
  localparam logic [4:0] REG_SCAN          = 5'd9;
  localparam logic [4:0] REG_CURSOR_START  = 5'd10;
  localparam logic [4:0] REG_CURSOR_END    = 5'd11;
  localparam logic [4:0] REG_START_H       = 5'd12;
  localparam logic [4:0] REG_START_L       = 5'd13;
  localparam logic [4:0] REG_CURSOR_H      = 5'd14;
  localparam logic [4:0] REG_CURSOR_L      = 5'd15;
  localparam logic [4:0] REG_PEN_H         = 5'd16;
  localparam logic [4:0] REG_PEN_L         = 5'd17;
  localparam logic [4:0] REG_UPDATE_H      = 5'd18;
  localparam logic [4:0] REG_UPDATE_L      = 5'd19;
  localparam logic [4:0] REG_UPDATE_STROBE = 5'd31;

  localparam logic [1:0] CURSOR_STEADY  = 2'd0;
  localparam logic [1:0] CURSOR_HIDDEN  = 2'd1;
  localparam logic [1:0] CURSOR_BLINK16 = 2'd2;

  localparam logic [5:0] BLINK_OFF  = 6'd0;
  localparam logic [5:0] BLINK_FAST = 6'd16;
  localparam logic [5:0] BLINK_SLOW = 6'd32;

  localparam logic [7:0] STATUS_STROBE = 8'h80;
  localparam logic [7:0] STATUS_PEN    = 8'h40;
  localparam logic [7:0] STATUS_VBLANK = 8'h20;
  localparam logic [7:0] READ_UNMAPPED = 8'hFF;

  typedef enum logic [2:0] {
    LEN_IDLE,
    LEN_MUL_VS,
    LEN_MUL_F,
    LEN_MUL_D,
    LEN_MUL_V,
    LEN_DONE
  } len_state_t;

  typedef struct packed {
    logic [8:0] htot;
    logic [7:0] vtot;
    logic [4:0] vadj;
    logic [6:0] vdisp;
    logic [5:0] scan;
  } timing_t;

  typedef struct packed {
    logic busy;
    logic done;
  } len_status_t;

endpackage

>>> hdl/crtc_mul.sv
// Registered unsigned multiplier shared by the length sequencer.
module crtc_mul (
  input  logic                        clk,
  input  logic [crtc_pkg::MUL_A_W-1:0] a,
  input  logic [crtc_pkg::MUL_B_W-1:0] b,
  output logic [crtc_pkg::PROD_W-1:0]  prod
);
  import crtc_pkg::*;

  always_ff @(posedge clk) begin
    prod <= PROD_W'(a) * PROD_W'(b);
  end

endmodule

>>> hdl/crtc_len.sv
// Sequencer that recomputes frame and vblank lengths on the shared multiplier.
`include "assert_macros.svh"
module crtc_len (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  crtc_pkg::timing_t         timing,
  output crtc_pkg::len_status_t     status,
  output logic [crtc_pkg::LEN_W-1:0] frame_length,
  output logic [crtc_pkg::LEN_W-1:0] vblank_length
);
  import crtc_pkg::*;

  len_state_t           state;
  len_state_t           state_next;
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [LEN_W-1:0]     f_hold;
  logic                 rows_ge;
  logic [7:0]           row_diff;
  logic [MUL_A_W-1:0]   adj_ext;
  logic [MUL_A_W-1:0]   v_inner;

  crtc_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign rows_ge  = timing.vtot >= {1'b0, timing.vdisp};
  assign row_diff = rows_ge ? timing.vtot - {1'b0, timing.vdisp}
                            : {1'b0, timing.vdisp} - timing.vtot;
  assign adj_ext  = MUL_A_W'(timing.vadj);

  // Blank scanlines plus adjust, floored at zero when displayed rows exceed total.
  always_comb begin
    if (rows_ge) begin
      v_inner = prod[MUL_A_W-1:0] + adj_ext;
    end else if (adj_ext > prod[MUL_A_W-1:0]) begin
      v_inner = adj_ext - prod[MUL_A_W-1:0];
    end else begin
      v_inner = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= LEN_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    mul_a       = '0;
    mul_b       = '0;
    status.busy = 1'b1;
    status.done = 1'b0;
    case (state)
      LEN_IDLE: begin
        status.busy = 1'b0;
        if (start) begin
          state_next = LEN_MUL_VS;
        end
      end
      LEN_MUL_VS: begin
        mul_a      = MUL_A_W'(timing.vtot);
        mul_b      = MUL_B_W'(timing.scan);
        state_next = LEN_MUL_F;
      end
      LEN_MUL_F: begin
        mul_a      = prod[MUL_A_W-1:0] + adj_ext;
        mul_b      = timing.htot;
        state_next = LEN_MUL_D;
      end
      LEN_MUL_D: begin
        mul_a      = MUL_A_W'(row_diff);
        mul_b      = MUL_B_W'(timing.scan);
        state_next = LEN_MUL_V;
      end
      LEN_MUL_V: begin
        mul_a      = v_inner;
        mul_b      = timing.htot;
        state_next = LEN_DONE;
      end
      LEN_DONE: begin
        status.done = 1'b1;
        state_next  = LEN_IDLE;
      end
      default: begin
        state_next = LEN_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (state == LEN_MUL_D) begin
      f_hold <= prod[LEN_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_length  <= LEN_W'(1);
      vblank_length <= '0;
    end else if (state == LEN_DONE) begin
      // A zero-length frame counts as one character clock.
      frame_length  <= (f_hold == '0) ? LEN_W'(1) : f_hold;
      vblank_length <= prod[LEN_W-1:0];
    end
  end

  `ASSERT_CLK(a_start_idle, start |-> !status.busy, "length start while busy")
  `ASSERT_CLK(a_start_busy, start |=> status.busy, "length start did not launch")
  `ASSERT_CLK(a_done_idle, status.done |=> !status.busy, "sequencer did not return to idle")
  `ASSERT_NEVER(a_frame_nonzero, frame_length == '0, "frame length is zero")

endmodule

>>> hdl/crt_controller_registers.sv
// Top level of the CRT controller register block.
// The result of a transaction is registered, and the next
// transaction enters in the cycle the result is taken. A data write to
// R0, R4, R5 or R9 waits while the single shared multiplier forms
// four products in sequence to rebuild the frame and vblank lengths; input
// is stalled until the result is loaded.
`include "assert_macros.svh"
module crt_controller_registers #(
  parameter int ADDR_BITS = 14,
  parameter int REG_COUNT = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [2:0]           op,
  input  logic [7:0]           write_value,
  input  logic [ADDR_BITS-1:0] pen_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [7:0]           read_value,
  output logic                 scan_all_request,
  output logic                 check_request,
  output logic [ADDR_BITS-1:0] check_address,
  output logic                 cursor_shown,
  output logic                 in_vblank
);
  import crtc_pkg::*;

  localparam logic [8:0] REG_MOD = 9'(REG_COUNT);

  logic                 accept;
  logic                 len_start;
  len_status_t          len_status;
  timing_t              timing;
  logic [LEN_W-1:0]     frame_length;
  logic [LEN_W-1:0]     vblank_length;

  logic [4:0]           selected_register;
  logic [7:0]           horizontal_displayed;
  logic [4:0]           cursor_first_line;
  logic [4:0]           cursor_last_line;
  logic [5:0]           blink_period;
  logic                 cursor_visible;
  logic [ADDR_BITS-1:0] display_start;
  logic [ADDR_BITS-1:0] cursor_address;
  logic [ADDR_BITS-1:0] update_address;
  logic [ADDR_BITS-1:0] pen_latch;
  logic                 pen_full;
  logic [5:0]           frames_counted;
  logic [LEN_W-1:0]     frame_position;

  logic [8:0]           sel_rem;
  logic [LEN_W-1:0]     pos_inc;
  logic [LEN_W-1:0]     frame_position_next;
  logic [5:0]           fc_inc;
  logic [5:0]           frames_counted_next;
  logic                 cursor_visible_next;
  logic                 blink_odd;
  logic                 vblank_now;
  logic [7:0]           data_byte;
  logic [7:0]           rv_result;

  function automatic logic [ADDR_BITS-1:0] set_high(logic [ADDR_BITS-1:0] word,
                                                    logic [7:0] v);
    logic [15:0] w;
    w = {v, word[7:0]};
    return w[ADDR_BITS-1:0];
  endfunction

  function automatic logic [ADDR_BITS-1:0] set_low(logic [ADDR_BITS-1:0] word,
                                                   logic [7:0] v);
    logic [15:0] w;
    w      = 16'(word);
    w[7:0] = v;
    return w[ADDR_BITS-1:0];
  endfunction

  function automatic logic [7:0] high_byte(logic [ADDR_BITS-1:0] word);
    logic [15:0] w;
    w = 16'(word);
    return w[15:8];
  endfunction

  assign accept     = in_valid && !in_stall;
  assign in_stall   = len_status.busy || (out_valid && out_stall);
  assign vblank_now = frame_position < vblank_length;
  assign len_start  = accept && (op == OP_WRITE_DATA) &&
                      (selected_register == REG_HTOT || selected_register == REG_VTOT ||
                       selected_register == REG_VADJ || selected_register == REG_SCAN);

  crtc_len u_len (
    .clk           (clk),
    .rst           (rst),
    .start         (len_start),
    .timing        (timing),
    .status        (len_status),
    .frame_length  (frame_length),
    .vblank_length (vblank_length)
  );

  // Reduce the selected address by subtracting scaled copies of the register count.
  always_comb begin
    sel_rem = {1'b0, write_value};
    for (int k = 3; k >= 0; k--) begin
      if (sel_rem >= (REG_MOD << k)) begin
        sel_rem = sel_rem - (REG_MOD << k);
      end
    end
  end

  // Advance the frame position; count the frame and run the cursor blink at its end.
  always_comb begin
    pos_inc             = frame_position + LEN_W'(1);
    fc_inc              = frames_counted + 6'd1;
    blink_odd           = (blink_period == BLINK_FAST) ? fc_inc[4] : fc_inc[5];
    frame_position_next = pos_inc;
    frames_counted_next = frames_counted;
    cursor_visible_next = cursor_visible;
    if (pos_inc >= frame_length) begin
      frame_position_next = '0;
      frames_counted_next = fc_inc;
      if (blink_period != BLINK_OFF && fc_inc > blink_period) begin
        if (blink_odd) begin
          cursor_visible_next = !cursor_visible;
        end
        frames_counted_next = (blink_period == BLINK_FAST) ? (fc_inc & 6'd15)
                                                           : (fc_inc & 6'd31);
      end
    end
  end

  always_comb begin
    case (selected_register)
      REG_CURSOR_H: data_byte = high_byte(cursor_address);
      REG_CURSOR_L: data_byte = cursor_address[7:0];
      REG_PEN_H:    data_byte = high_byte(pen_latch);
      REG_PEN_L:    data_byte = pen_latch[7:0];
      default:      data_byte = READ_UNMAPPED;
    endcase
  end

  always_comb begin
    case (op)
      OP_READ_STATUS: begin
        rv_result = STATUS_STROBE | (pen_full ? STATUS_PEN : 8'h00) |
                    (vblank_now ? STATUS_VBLANK : 8'h00);
      end
      OP_READ_DATA: rv_result = data_byte;
      default:      rv_result = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      selected_register    <= '0;
      timing               <= '0;
      horizontal_displayed <= '0;
      cursor_first_line    <= '0;
      cursor_last_line     <= '0;
      blink_period         <= BLINK_OFF;
      cursor_visible       <= 1'b0;
      display_start        <= '0;
      cursor_address       <= '0;
      update_address       <= '0;
      pen_latch            <= '0;
      pen_full             <= 1'b0;
      frames_counted       <= '0;
      frame_position       <= '0;
    end else if (accept) begin
      case (op)
        OP_WRITE_ADDR: selected_register <= sel_rem[4:0];
        OP_WRITE_DATA: begin
          case (selected_register)
            REG_HTOT:    timing.htot          <= {1'b0, write_value} + 9'd1;
            REG_HDISP:   horizontal_displayed <= write_value;
            REG_VTOT:    timing.vtot          <= {1'b0, write_value[6:0]} + 8'd1;
            REG_VADJ:    timing.vadj          <= write_value[4:0];
            REG_VDISP:   timing.vdisp         <= write_value[6:0];
            REG_SCAN:    timing.scan          <= {1'b0, write_value[4:0]} + 6'd1;
            REG_CURSOR_START: begin
              cursor_first_line <= write_value[4:0];
              case (write_value[6:5])
                CURSOR_STEADY: begin
                  cursor_visible <= 1'b1;
                  blink_period   <= BLINK_OFF;
                end
                CURSOR_HIDDEN: begin
                  cursor_visible <= 1'b0;
                  blink_period   <= BLINK_OFF;
                end
                CURSOR_BLINK16: blink_period <= BLINK_FAST;
                default:        blink_period <= BLINK_SLOW;
              endcase
            end
            REG_CURSOR_END: cursor_last_line <= write_value[4:0];
            REG_START_H:    display_start    <= set_high(display_start, write_value);
            REG_START_L:    display_start    <= set_low(display_start, write_value);
            REG_CURSOR_H:   cursor_address   <= set_high(cursor_address, write_value);
            REG_CURSOR_L:   cursor_address   <= set_low(cursor_address, write_value);
            REG_UPDATE_H:   update_address   <= set_high(update_address, write_value);
            REG_UPDATE_L:   update_address   <= set_low(update_address, write_value);
            default: begin
            end
          endcase
        end
        OP_READ_DATA: begin
          if (selected_register == REG_PEN_H || selected_register == REG_PEN_L) begin
            pen_full <= 1'b0;
          end
        end
        OP_TICK: begin
          frame_position <= frame_position_next;
          frames_counted <= frames_counted_next;
          cursor_visible <= cursor_visible_next;
        end
        OP_PEN_STROBE: begin
          if (!pen_full) begin
            pen_full  <= 1'b1;
            pen_latch <= pen_address;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Hold the result until taken; a length write loads it when the sequencer finishes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && !len_start) || len_status.done) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_value       <= rv_result;
      scan_all_request <= (op == OP_READ_STATUS) && !pen_full;
      check_request    <= (op == OP_WRITE_DATA) && (selected_register == REG_UPDATE_STROBE);
      check_address    <= ((op == OP_WRITE_DATA) && (selected_register == REG_UPDATE_STROBE))
                          ? update_address : '0;
    end
  end

  // State cannot move while a result waits, so these track the item just delivered.
  assign cursor_shown = cursor_visible;
  assign in_vblank    = vblank_now;

  `ASSERT_CLK(a_len_stalls, len_start |=> in_stall, "input not stalled during length update")
  `ASSERT_CLK(a_pen_rise, $rose(pen_full) |-> $past(accept) && $past(op) == OP_PEN_STROBE,
              "pen latch filled without a strobe")
  `ASSERT_CLK(a_scan_status, out_valid && scan_all_request |-> read_value[7],
              "scan request without a status byte")

endmodule
